FILE: sv/dfpm_pkg.sv
// ----------------------------------------------------------------------------
// dfpm_pkg
// Shared types and constants of the display frame performance monitor.
// ----------------------------------------------------------------------------
package dfpm_pkg;

    typedef logic [47:0] time_t;
    typedef logic [63:0] total_t;

    // Event codes.
    localparam logic [2:0] OP_INVALIDATE  = 3'd0;
    localparam logic [2:0] OP_REFR_START  = 3'd1;
    localparam logic [2:0] OP_RENDER_START = 3'd2;
    localparam logic [2:0] OP_RENDER_READY = 3'd3;
    localparam logic [2:0] OP_FLUSH_START = 3'd4;
    localparam logic [2:0] OP_WAIT_START  = 3'd5;
    localparam logic [2:0] OP_WAIT_FINISH = 3'd6;
    localparam logic [2:0] OP_REFR_READY  = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIXEL_CLOCK = 2'd0;
    localparam logic [1:0] CFG_PERIOD      = 2'd1;
    localparam logic [1:0] CFG_WIN_START   = 2'd2;

    localparam logic [27:0] PIXEL_CLOCK_RST = 28'd40000000;
    localparam logic [26:0] PERIOD_RST      = 27'd1000000;

    localparam logic [23:0] SCALE_RATE   = 24'd10000000;
    // Bits per pixel times the rate scale.
    localparam logic [27:0] WIRE_SCALE   = 28'd160000000;
    localparam logic [63:0] US_PER_MS    = 64'd1000;
    localparam logic [63:0] PEAK_DIV     = 64'd100;

endpackage

FILE: sv/display_frame_perf_monitor.sv
// ----------------------------------------------------------------------------
// display_frame_perf_monitor
// Collects per-frame display timings and reports window averages.
// ----------------------------------------------------------------------------
// Events enter on the in channel (valid/ready) with a timestamp and an
// optional pixel area. Every event except refresh ready is absorbed at once
// and in_ready stays high. A refresh ready event folds the frame into the
// window; when the window has lasted the report period and holds frames,
// the block computes one snapshot and drops in_ready until it is done.
// The snapshot needs sixteen 64-bit divisions on one restoring divider that
// retires one quotient bit per cycle, after the constant multiplications in
// the MUL_LO and MUL_HI states.
// The snapshot is presented on the out channel (valid/ready) and held until
// taken. While it waits, further events are still accepted; a second report
// waits for the first to be taken before its computation starts.
// Configuration is a plain write port; writing the window start register
// also restarts the current window at that time.
// Reset clears all counters and sums, loads the register defaults and leaves
// the out channel empty.
// ----------------------------------------------------------------------------
module display_frame_perf_monitor
    import dfpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [47:0] time_us,
    input  logic        area_present,
    input  logic [23:0] area_pixels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sequence_res,
    output logic [31:0] duration_ms,
    output logic [31:0] updates_per_s_x10,
    output logic [31:0] submit_mean_ms_x10,
    output logic [25:0] submit_peak_ms_x10,
    output logic [31:0] render_mean_ms_x10,
    output logic [31:0] wait_avg_ms_x10,
    output logic [31:0] pixels_per_frame,
    output logic [31:0] flush_rate_x10,
    output logic [31:0] inval_rate_x10,
    output logic [31:0] inval_pixels_mean,
    output logic [31:0] wire_time_ms_x10
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_MUL_LO = 3'd2;
    localparam logic [2:0] ST_MUL_HI = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;

    localparam logic [3:0] LAST_STEP = 4'd15;

    logic [2:0]  st_reg;
    logic [27:0] clk_hz_reg;
    logic [26:0] period_cfg_reg;
    time_t       refresh_start_reg, render_start_reg, wait_start_reg, win_start_reg;
    time_t       now_reg, period_reg;
    total_t      submit_tot_reg, render_tot_reg, wait_tot_reg, pixel_tot_reg;
    total_t      ireq_tot_reg, ipix_tot_reg;
    logic [31:0] peak_reg, fcount_reg, flush_tot_reg, pend_req_reg, pend_pix_reg;
    logic [31:0] fr_render_reg, fr_wait_reg, fr_pix_reg, fr_req_reg, fr_ipix_reg;
    logic [31:0] snap_cnt_reg;
    logic [15:0] fr_flush_reg;
    logic        rendered_reg, rendering_reg;
    logic        out_valid_reg;

    // Report datapath.
    total_t      cpu_reg, prod_lo_reg, prod_hi_reg, q_reg;
    logic [3:0]  step_reg;
    logic [5:0]  iter_reg;
    logic [64:0] rem_reg;
    total_t      quo_reg, dsr_reg;
    logic [31:0] r_seq_reg, r_dur_reg, r_ups_reg, r_sub_reg, r_rnd_reg, r_wait_reg;
    logic [31:0] r_ppu_reg, r_flx_reg, r_inv_reg, r_ipx_reg, r_wire_reg;
    logic [25:0] r_smax_reg;

    logic        accept;
    time_t       now;
    time_t       period_now;
    logic        fold;
    logic [31:0] submit;
    logic [31:0] fcount_new;
    total_t      dividend_mux, divisor_mux;
    logic [64:0] rem_sh;
    logic [65:0] trial;
    logic        ge;
    total_t      quo_next;

    assign in_ready  = (st_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign now       = time_us;
    assign out_valid = out_valid_reg;

    assign period_now = now - win_start_reg;
    assign fold       = rendered_reg && (fr_pix_reg != 32'd0);
    assign submit     = 32'(now - refresh_start_reg);
    assign fcount_new = fold ? fcount_reg + 32'd1 : fcount_reg;

    // Operand selection for each division of the report.
    always_comb
    begin
        dividend_mux = q_reg;
        divisor_mux  = US_PER_MS;
        unique case (step_reg)
            4'd0:  dividend_mux = {16'd0, period_reg};
            4'd1:
            begin
                dividend_mux = 64'(fcount_reg * SCALE_RATE);
                divisor_mux  = {16'd0, period_reg};
            end
            4'd2:
            begin
                dividend_mux = (submit_tot_reg << 3) + (submit_tot_reg << 1);
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd4:
            begin
                dividend_mux = (cpu_reg << 3) + (cpu_reg << 1);
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd6:
            begin
                dividend_mux = (wait_tot_reg << 3) + (wait_tot_reg << 1);
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd8:
            begin
                dividend_mux = pixel_tot_reg;
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd9:
            begin
                dividend_mux = {32'd0, (flush_tot_reg << 3) + (flush_tot_reg << 1)};
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd10:
            begin
                dividend_mux = (ireq_tot_reg << 3) + (ireq_tot_reg << 1);
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd11:
            begin
                dividend_mux = ipix_tot_reg;
                divisor_mux  = {32'd0, fcount_reg};
            end
            4'd12:
            begin
                dividend_mux = {32'd0, peak_reg};
                divisor_mux  = PEAK_DIV;
            end
            4'd13:
            begin
                dividend_mux = prod_lo_reg + {prod_hi_reg[31:0], 32'd0};
                divisor_mux  = {36'd0, clk_hz_reg};
            end
            4'd14:   divisor_mux = {32'd0, fcount_reg};
            default: divisor_mux = US_PER_MS;
        endcase
    end

    // One restoring step of the shared divider.
    assign rem_sh   = {rem_reg[63:0], quo_reg[63]};
    assign trial    = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign ge       = !trial[65];
    assign quo_next = {quo_reg[62:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg            <= ST_IDLE;
            clk_hz_reg        <= PIXEL_CLOCK_RST;
            period_cfg_reg    <= PERIOD_RST;
            refresh_start_reg <= '0;
            render_start_reg  <= '0;
            wait_start_reg    <= '0;
            win_start_reg     <= '0;
            submit_tot_reg    <= '0;
            render_tot_reg    <= '0;
            wait_tot_reg      <= '0;
            pixel_tot_reg     <= '0;
            ireq_tot_reg      <= '0;
            ipix_tot_reg      <= '0;
            peak_reg          <= '0;
            fcount_reg        <= '0;
            flush_tot_reg     <= '0;
            pend_req_reg      <= '0;
            pend_pix_reg      <= '0;
            fr_render_reg     <= '0;
            fr_wait_reg       <= '0;
            fr_pix_reg        <= '0;
            fr_req_reg        <= '0;
            fr_ipix_reg       <= '0;
            fr_flush_reg      <= '0;
            rendered_reg      <= 1'b0;
            rendering_reg     <= 1'b0;
            snap_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
            iter_reg          <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PIXEL_CLOCK: clk_hz_reg <= cfg_data[27:0];
                    CFG_PERIOD:      period_cfg_reg <= cfg_data[26:0];
                    CFG_WIN_START:   win_start_reg <= cfg_data;
                    default:         ;
                endcase
            end

            unique case (st_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (op)
                            OP_INVALIDATE:
                            begin
                                if (!rendering_reg && area_present)
                                begin
                                    pend_req_reg <= pend_req_reg + 32'd1;
                                    pend_pix_reg <= pend_pix_reg + {8'd0, area_pixels};
                                end
                            end
                            OP_REFR_START:
                            begin
                                refresh_start_reg <= now;
                                fr_render_reg     <= '0;
                                fr_wait_reg       <= '0;
                                fr_pix_reg        <= '0;
                                fr_flush_reg      <= '0;
                                fr_req_reg        <= pend_req_reg;
                                fr_ipix_reg       <= pend_pix_reg;
                                pend_req_reg      <= '0;
                                pend_pix_reg      <= '0;
                                rendered_reg      <= 1'b0;
                                rendering_reg     <= 1'b0;
                            end
                            OP_RENDER_START:
                            begin
                                rendered_reg     <= 1'b1;
                                rendering_reg    <= 1'b1;
                                render_start_reg <= now;
                            end
                            OP_RENDER_READY:
                            begin
                                fr_render_reg <= fr_render_reg + 32'(now - render_start_reg);
                                rendering_reg <= 1'b0;
                            end
                            OP_FLUSH_START:
                            begin
                                if (area_present)
                                begin
                                    fr_pix_reg   <= fr_pix_reg + {8'd0, area_pixels};
                                    fr_flush_reg <= fr_flush_reg + 16'd1;
                                end
                            end
                            OP_WAIT_START:  wait_start_reg <= now;
                            OP_WAIT_FINISH:
                            begin
                                fr_wait_reg <= fr_wait_reg + 32'(now - wait_start_reg);
                            end
                            OP_REFR_READY:
                            begin
                                if (fold)
                                begin
                                    submit_tot_reg <= submit_tot_reg + {32'd0, submit};
                                    render_tot_reg <= render_tot_reg + {32'd0, fr_render_reg};
                                    wait_tot_reg   <= wait_tot_reg + {32'd0, fr_wait_reg};
                                    pixel_tot_reg  <= pixel_tot_reg + {32'd0, fr_pix_reg};
                                    flush_tot_reg  <= flush_tot_reg + {16'd0, fr_flush_reg};
                                    ireq_tot_reg   <= ireq_tot_reg + {32'd0, fr_req_reg};
                                    ipix_tot_reg   <= ipix_tot_reg + {32'd0, fr_ipix_reg};
                                    fcount_reg     <= fcount_new;
                                    if (submit > peak_reg)
                                    begin
                                        peak_reg <= submit;
                                    end
                                end
                                now_reg    <= now;
                                period_reg <= period_now;
                                if (period_now >= {21'd0, period_cfg_reg})
                                begin
                                    if (fcount_new == 32'd0)
                                    begin
                                        // Window elapsed with no frames: just restart it.
                                        win_start_reg <= now;
                                    end
                                    else
                                    begin
                                        snap_cnt_reg <= snap_cnt_reg + 32'd1;
                                        st_reg       <= ST_WAIT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WAIT:
                begin
                    // The result registers are reused, so the last snapshot must be gone.
                    if (!out_valid_reg)
                    begin
                        st_reg    <= ST_MUL_LO;
                        r_seq_reg <= snap_cnt_reg;
                    end
                end
                ST_MUL_LO:
                begin
                    prod_lo_reg <= 64'(pixel_tot_reg[31:0] * WIRE_SCALE);
                    cpu_reg     <= (render_tot_reg >= wait_tot_reg) ?
                                   render_tot_reg - wait_tot_reg : '0;
                    st_reg      <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    prod_hi_reg <= 64'(pixel_tot_reg[63:32] * WIRE_SCALE);
                    step_reg    <= '0;
                    st_reg      <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    rem_reg  <= '0;
                    quo_reg  <= dividend_mux;
                    dsr_reg  <= divisor_mux;
                    iter_reg <= '0;
                    st_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= ge ? trial[64:0] : rem_sh;
                    quo_reg  <= quo_next;
                    iter_reg <= iter_reg + 6'd1;
                    if (iter_reg == 6'd63)
                    begin
                        q_reg <= quo_next;
                        unique case (step_reg)
                            4'd0:  r_dur_reg  <= quo_next[31:0];
                            4'd1:  r_ups_reg  <= quo_next[31:0];
                            4'd3:  r_sub_reg  <= quo_next[31:0];
                            4'd5:  r_rnd_reg  <= quo_next[31:0];
                            4'd7:  r_wait_reg <= quo_next[31:0];
                            4'd8:  r_ppu_reg  <= quo_next[31:0];
                            4'd9:  r_flx_reg  <= quo_next[31:0];
                            4'd10: r_inv_reg  <= quo_next[31:0];
                            4'd11: r_ipx_reg  <= quo_next[31:0];
                            4'd12: r_smax_reg <= quo_next[25:0];
                            4'd15:
                            begin
                                // A zero pixel clock saturates the wire time.
                                r_wire_reg <= (clk_hz_reg == 28'd0) ? 32'hFFFF_FFFF :
                                              quo_next[31:0];
                            end
                            default: ;
                        endcase
                        if (step_reg == LAST_STEP)
                        begin
                            out_valid_reg  <= 1'b1;
                            st_reg         <= ST_IDLE;
                            win_start_reg  <= now_reg;
                            submit_tot_reg <= '0;
                            render_tot_reg <= '0;
                            wait_tot_reg   <= '0;
                            pixel_tot_reg  <= '0;
                            ireq_tot_reg   <= '0;
                            ipix_tot_reg   <= '0;
                            peak_reg       <= '0;
                            fcount_reg     <= '0;
                            flush_tot_reg  <= '0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                            st_reg   <= ST_LOAD;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign sequence_res       = r_seq_reg;
    assign duration_ms        = r_dur_reg;
    assign updates_per_s_x10  = r_ups_reg;
    assign submit_mean_ms_x10 = r_sub_reg;
    assign submit_peak_ms_x10 = r_smax_reg;
    assign render_mean_ms_x10 = r_rnd_reg;
    assign wait_avg_ms_x10    = r_wait_reg;
    assign pixels_per_frame   = r_ppu_reg;
    assign flush_rate_x10     = r_flx_reg;
    assign inval_rate_x10     = r_inv_reg;
    assign inval_pixels_mean  = r_ipx_reg;
    assign wire_time_ms_x10   = r_wire_reg;

endmodule

FILE: sv/dfpm_checker.sv
// ----------------------------------------------------------------------------
// dfpm_checker
// Port-level checks of the display frame performance monitor.
// ----------------------------------------------------------------------------
module dfpm_checker
    import dfpm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] sequence_res
);

    // A stalled snapshot holds its number.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sequence_res))
        else $error("snapshot changed while stalled");

    // Events other than refresh ready never stall the input.
    a_fast_event: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op != OP_REFR_READY |=> in_ready)
        else $error("input stalled after a plain event");

    // A snapshot only appears at the end of a report computation.
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("snapshot appeared without a report computation");

    // Reports take many cycles, so a taken snapshot is never followed at once.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("second snapshot right after the first");

endmodule

bind display_frame_perf_monitor dfpm_checker u_dfpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sequence_res (sequence_res)
);

FILE: tb/sv/display_frame_perf_monitor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_frame_perf_monitor_tb
// Self-checking testbench for the display frame performance monitor.
// ----------------------------------------------------------------------------
// Drives display-pipeline events through the valid/ready input channel,
// predicts each window snapshot with a behavioral copy of the frame and window
// bookkeeping, and compares every snapshot field by field. A directed table
// covers the extremes and corner cases. Random frame sequences follow, run
// under several register settings, with random idling on both sides, a long
// receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module display_frame_perf_monitor_tb;
    import dfpm_pkg::*;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [47:0] TMASK       = 48'hFFFF_FFFF_FFFF;
    // Index with no register behind it.
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;

    typedef struct {
        logic [31:0] seq_no;
        logic [31:0] dur;
        logic [31:0] ups;
        logic [31:0] sub_avg;
        logic [25:0] sub_max;
        logic [31:0] ren_avg;
        logic [31:0] wait_avg;
        logic [31:0] pix_avg;
        logic [31:0] flushes;
        logic [31:0] invals;
        logic [31:0] inv_pix;
        logic [31:0] wire_min;
    } snapshot_t;

    typedef struct {
        logic [2:0]  code;
        logic [47:0] stamp;
        logic        has_area;
        logic [23:0] pixels;
        logic        check_seq;    // typed-in snapshot number to compare
        logic [31:0] seq_expect;
    } event_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [47:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [2:0] op;
    logic [47:0] time_us;
    logic area_present;
    logic [23:0] area_pixels;
    logic out_valid;
    logic out_ready;
    logic [31:0] sequence_res;
    logic [31:0] duration_ms;
    logic [31:0] updates_per_s_x10;
    logic [31:0] submit_mean_ms_x10;
    logic [25:0] submit_peak_ms_x10;
    logic [31:0] render_mean_ms_x10;
    logic [31:0] wait_avg_ms_x10;
    logic [31:0] pixels_per_frame;
    logic [31:0] flush_rate_x10;
    logic [31:0] inval_rate_x10;
    logic [31:0] inval_pixels_mean;
    logic [31:0] wire_time_ms_x10;

    display_frame_perf_monitor dut (.*);

    // Predictor state.
    logic [63:0] clk_hz, win_period;
    logic [47:0] t_refresh, t_render, t_wait, t_window;
    logic [63:0] sum_submit, sum_render, sum_wait, sum_pixels, sum_inv_req, sum_inv_pix;
    logic [31:0] peak_submit, frames, sum_flushes, pend_req, pend_pix;
    logic [31:0] fr_render, fr_wait, fr_pixels, fr_req, fr_inv_pix, snap_no;
    logic [15:0] fr_flushes;
    logic        was_rendered, in_render;

    snapshot_t   expected_snaps[$];
    int          mismatches;
    int          snaps_seen;
    int          events_sent;
    int          cycles;
    bit          quiet_phase;      // no idling on either side
    bit          hold_receiver;
    logic [47:0] now_us;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("display_frame_perf_monitor_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d (snapshot %0d)", what, got, want,
                 snaps_seen);
    endtask

    task automatic clear_window_sums(input logic [47:0] now);
        t_window = now;
        sum_submit = '0; sum_render = '0; sum_wait = '0; sum_pixels = '0;
        sum_inv_req = '0; sum_inv_pix = '0;
        peak_submit = '0; frames = '0; sum_flushes = '0;
    endtask

    task automatic reset_predictor();
        clk_hz = 64'(PIXEL_CLOCK_RST);
        win_period = 64'(PERIOD_RST);
        t_refresh = '0; t_render = '0; t_wait = '0;
        clear_window_sums('0);
        pend_req = '0; pend_pix = '0;
        fr_render = '0; fr_wait = '0; fr_pixels = '0; fr_req = '0; fr_inv_pix = '0;
        fr_flushes = '0; was_rendered = 1'b0; in_render = 1'b0; snap_no = '0;
    endtask

    // Applies each event; a refresh ready folds the frame in and, when the window is due, queues its snapshot.
    task automatic predict_event(input event_row_t ev);
        logic [63:0] span, f, busy;
        logic [31:0] sub;
        snapshot_t   s;
        case (ev.code)
            OP_INVALIDATE:
                if (!in_render && ev.has_area)
                begin
                    pend_req++;
                    pend_pix += 32'(ev.pixels);
                end
            OP_REFR_START:
            begin
                t_refresh = ev.stamp;
                fr_render = '0; fr_wait = '0; fr_pixels = '0; fr_flushes = '0;
                fr_req = pend_req; fr_inv_pix = pend_pix;
                pend_req = '0; pend_pix = '0;
                was_rendered = 1'b0; in_render = 1'b0;
            end
            OP_RENDER_START:
            begin
                was_rendered = 1'b1; in_render = 1'b1;
                t_render = ev.stamp;
            end
            OP_RENDER_READY:
            begin
                fr_render += 32'((ev.stamp - t_render) & TMASK);
                in_render = 1'b0;
            end
            OP_FLUSH_START:
                if (ev.has_area)
                begin
                    fr_pixels += 32'(ev.pixels);
                    fr_flushes++;
                end
            OP_WAIT_START:
                t_wait = ev.stamp;
            OP_WAIT_FINISH:
                fr_wait += 32'((ev.stamp - t_wait) & TMASK);
            default:
            begin
                if (was_rendered && fr_pixels > 0)
                begin
                    sub = 32'((ev.stamp - t_refresh) & TMASK);
                    sum_submit += 64'(sub);
                    sum_render += 64'(fr_render);
                    sum_wait += 64'(fr_wait);
                    sum_pixels += 64'(fr_pixels);
                    sum_flushes += 32'(fr_flushes);
                    sum_inv_req += 64'(fr_req);
                    sum_inv_pix += 64'(fr_inv_pix);
                    if (sub > peak_submit)
                        peak_submit = sub;
                    frames++;
                end
                span = 64'((ev.stamp - t_window) & TMASK);
                if (span >= win_period)
                begin
                    if (frames != 0)
                    begin
                        f = 64'(frames);
                        snap_no++;
                        busy = (sum_render >= sum_wait) ? sum_render - sum_wait : '0;
                        s.seq_no   = snap_no;
                        s.dur      = 32'(span / 1000);
                        s.ups      = (span == 0) ? 32'hFFFF_FFFF : 32'((f * 10000000) / span);
                        s.sub_avg  = 32'((sum_submit * 10) / f / 1000);
                        s.sub_max  = 26'(peak_submit / 100);
                        s.ren_avg  = 32'((busy * 10) / f / 1000);
                        s.wait_avg = 32'((sum_wait * 10) / f / 1000);
                        s.pix_avg  = 32'(sum_pixels / f);
                        s.flushes  = 32'(sum_flushes * 32'd10) / frames;
                        s.invals   = 32'((sum_inv_req * 10) / f);
                        s.inv_pix  = 32'(sum_inv_pix / f);
                        s.wire_min = (clk_hz == 0) ? 32'hFFFF_FFFF :
                            32'((sum_pixels * 64'd16 * 64'd10000000) / clk_hz / f / 1000);
                        expected_snaps.push_back(s);
                    end
                    clear_window_sums(ev.stamp);
                end
            end
        endcase
    endtask

    // Checks each snapshot taken from the output channel.
    always @(posedge clk)
    begin
        snapshot_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_snaps.size() == 0)
            begin
                report_mismatch("unexpected snapshot", 64'(sequence_res), 64'd0);
            end
            else
            begin
                w = expected_snaps.pop_front();
                snaps_seen++;
                if (sequence_res !== w.seq_no) report_mismatch("sequence", sequence_res, w.seq_no);
                if (duration_ms !== w.dur) report_mismatch("duration", duration_ms, w.dur);
                if (updates_per_s_x10 !== w.ups) report_mismatch("updates", updates_per_s_x10, w.ups);
                if (submit_mean_ms_x10 !== w.sub_avg)
                    report_mismatch("submit_mean", submit_mean_ms_x10, w.sub_avg);
                if (submit_peak_ms_x10 !== w.sub_max)
                    report_mismatch("submit_peak", submit_peak_ms_x10, w.sub_max);
                if (render_mean_ms_x10 !== w.ren_avg)
                    report_mismatch("render_mean", render_mean_ms_x10, w.ren_avg);
                if (wait_avg_ms_x10 !== w.wait_avg)
                    report_mismatch("wait_avg", wait_avg_ms_x10, w.wait_avg);
                if (pixels_per_frame !== w.pix_avg)
                    report_mismatch("pixels", pixels_per_frame, w.pix_avg);
                if (flush_rate_x10 !== w.flushes) report_mismatch("flushes", flush_rate_x10, w.flushes);
                if (inval_rate_x10 !== w.invals)
                    report_mismatch("invalidations", inval_rate_x10, w.invals);
                if (inval_pixels_mean !== w.inv_pix)
                    report_mismatch("inval_pixels", inval_pixels_mean, w.inv_pix);
                if (wire_time_ms_x10 !== w.wire_min)
                    report_mismatch("wire_time", wire_time_ms_x10, w.wire_min);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_receiver)
            out_ready <= 1'b0;
        else if (quiet_phase)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 9);
    end

    task automatic write_register(input logic [1:0] idx, input logic [47:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PIXEL_CLOCK: clk_hz = 64'(value[27:0]);
            CFG_PERIOD:      win_period = 64'(value[26:0]);
            CFG_WIN_START:   t_window = value;
            default: ;
        endcase
    endtask

    // Offers one event, holding it until accepted; starts and ends at a falling
    // edge. Valid stays high afterwards so that the next item can follow
    // directly; the caller drops it when the sender goes quiet.
    task automatic send_event(input event_row_t ev);
        if (!quiet_phase)
            while ($urandom_range(99) < 9)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        op <= ev.code;
        time_us <= ev.stamp;
        area_present <= ev.has_area;
        area_pixels <= ev.pixels;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_event(ev);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_snaps.size() != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    function automatic event_row_t make_row(input logic [2:0] c, input logic [47:0] t,
                                            input logic a, input logic [23:0] px);
        event_row_t r;
        r.code = c; r.stamp = t; r.has_area = a; r.pixels = px;
        r.check_seq = 1'b0; r.seq_expect = '0;
        return r;
    endfunction

    // One well-formed frame with random content, occasionally broken.
    task automatic send_frame();
        int n;
        bit broken;
        broken = ($urandom_range(9) == 0);
        n = $urandom_range(2);
        repeat (n)
        begin
            now_us += $urandom_range(50);
            send_event(make_row(OP_INVALIDATE, now_us, $urandom_range(7) != 0, 24'($urandom)));
        end
        now_us += $urandom_range(2000);
        send_event(make_row(OP_REFR_START, now_us, $urandom_range(1), 24'($urandom)));
        if (!broken || $urandom_range(1))
        begin
            now_us += $urandom_range(100);
            send_event(make_row(OP_RENDER_START, now_us, $urandom_range(1), 24'($urandom)));
            if ($urandom_range(3) == 0)
                send_event(make_row(OP_INVALIDATE, now_us, 1'b1, 24'($urandom)));
            now_us += $urandom_range(20000);
            send_event(make_row(OP_RENDER_READY, now_us, $urandom_range(1), 24'($urandom)));
        end
        n = $urandom_range(3);
        repeat (n)
        begin
            now_us += $urandom_range(100);
            send_event(make_row(OP_FLUSH_START, now_us, $urandom_range(5) != 0,
                                ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(80000))));
            now_us += $urandom_range(100);
            send_event(make_row(OP_WAIT_START, now_us, $urandom_range(1), 24'($urandom)));
            now_us += $urandom_range(5000);
            send_event(make_row(OP_WAIT_FINISH, now_us, $urandom_range(1), 24'($urandom)));
        end
        if (broken && $urandom_range(1))
            now_us -= $urandom_range(3000);
        else
            now_us += $urandom_range(8000);
        send_event(make_row(OP_REFR_READY, now_us, $urandom_range(1), 24'($urandom)));
    endtask

    task automatic run_frames(input int count);
        repeat (count)
            send_frame();
        in_valid <= 1'b0;
        while (expected_snaps.size() != 0)
            @(negedge clk);
    endtask

    event_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_PIXEL_CLOCK; cfg_data = '0;
        in_valid = 1'b0; op = OP_INVALIDATE; time_us = '0;
        area_present = 1'b0; area_pixels = '0;
        out_ready = 1'b0;
        mismatches = 0; snaps_seen = 0; events_sent = 0; cycles = 0;
        quiet_phase = 1'b0; hold_receiver = 1'b0;
        reset_predictor();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under reset defaults, then period zero for quick windows.
        directed_rows = '{
            make_row(OP_INVALIDATE, 48'd10, 1'b1, 24'hFFFFFF),
            make_row(OP_INVALIDATE, 48'd11, 1'b0, 24'd5),
            make_row(OP_REFR_START, 48'd20, 1'b0, 24'd0),
            make_row(OP_RENDER_START, 48'd30, 1'b1, 24'd0),
            make_row(OP_INVALIDATE, 48'd31, 1'b1, 24'd99),
            make_row(OP_RENDER_READY, 48'd5030, 1'b0, 24'd0),
            make_row(OP_FLUSH_START, 48'd5040, 1'b0, 24'd7),
            make_row(OP_FLUSH_START, 48'd5050, 1'b1, 24'hFFFFFF),
            make_row(OP_WAIT_START, 48'd5060, 1'b0, 24'd0),
            make_row(OP_WAIT_FINISH, 48'd9060, 1'b0, 24'd0),
            make_row(OP_REFR_READY, 48'd1000000, 1'b0, 24'd0),
            make_row(OP_REFR_READY, 48'd3000000, 1'b0, 24'd0)
        };
        directed_rows[10].check_seq = 1'b1;
        directed_rows[10].seq_expect = 32'd1;
        foreach (directed_rows[i])
        begin
            send_event(directed_rows[i]);
            if (directed_rows[i].check_seq &&
                (expected_snaps.size() == 0 ||
                 expected_snaps[expected_snaps.size() - 1].seq_no !== directed_rows[i].seq_expect))
                report_mismatch("directed sequence", 0, directed_rows[i].seq_expect);
        end
        wait_drained();

        // Extremes: period zero, pixel clock zero, window start at the top of time.
        write_register(CFG_PERIOD, 48'd0);
        write_register(CFG_PIXEL_CLOCK, 48'd0);
        write_register(CFG_WIN_START, TMASK);
        now_us = TMASK - 48'd5;
        send_event(make_row(OP_REFR_START, now_us, 1'b0, 24'd0));
        send_event(make_row(OP_RENDER_START, now_us, 1'b0, 24'd0));
        send_event(make_row(OP_RENDER_READY, now_us + 48'd10, 1'b0, 24'd0));
        send_event(make_row(OP_FLUSH_START, now_us + 48'd11, 1'b1, 24'd1));
        // Wraps through zero; same stamp twice gives a zero-length window.
        send_event(make_row(OP_REFR_READY, now_us + 48'd20, 1'b0, 24'd0));
        send_event(make_row(OP_REFR_START, now_us + 48'd20, 1'b0, 24'd0));
        send_event(make_row(OP_RENDER_START, now_us + 48'd20, 1'b0, 24'd0));
        send_event(make_row(OP_FLUSH_START, now_us + 48'd20, 1'b1, 24'd3));
        send_event(make_row(OP_REFR_READY, now_us + 48'd20, 1'b0, 24'd0));
        wait_drained();
        write_register(CFG_PIXEL_CLOCK, 48'hFFF_FFFF);
        write_register(CFG_PERIOD, 48'h7FF_FFFF);
        write_register(CFG_WIN_START, 48'd0);
        write_register(CFG_UNUSED, 48'd12345);   // ignored

        // Random phases under several settings; short periods so windows close.
        now_us = 48'd100;
        write_register(CFG_PERIOD, 48'd30000);
        write_register(CFG_PIXEL_CLOCK, 48'd40000000);
        write_register(CFG_WIN_START, now_us);
        run_frames(24);

        // Receiver holds off while frames keep coming and fill the block.
        write_register(CFG_PERIOD, 48'd0);
        fork
            begin
                hold_receiver = 1'b1;
                repeat (6000) @(negedge clk);
                hold_receiver = 1'b0;
            end
            run_frames(8);
        join
        wait_drained();

        quiet_phase = 1'b1;
        write_register(CFG_PERIOD, 48'd1);
        write_register(CFG_PIXEL_CLOCK, 48'd1);
        run_frames(12);
        quiet_phase = 1'b0;
        wait_drained();

        write_register(CFG_PERIOD, 48'd60000);
        write_register(CFG_PIXEL_CLOCK, 48'($urandom_range(200000000, 1)));
        write_register(CFG_WIN_START, now_us - 48'd100);
        run_frames(16);
        wait_drained();

        write_register(CFG_PERIOD, 48'd15000);
        write_register(CFG_PIXEL_CLOCK, 48'd200000000);
        run_frames(16);

        wait_drained();
        $display("%0d events sent, %0d snapshots checked, %0d mismatches",
                 events_sent, snaps_seen, mismatches);
        $display("covered register extremes, wrapped timestamps, receiver hold-off");
        if (mismatches == 0 && expected_snaps.size() == 0)
            $display("display_frame_perf_monitor_tb: PASS");
        else
            $display("display_frame_perf_monitor_tb: FAIL");
        $finish;
    end

endmodule
